>>> rtl/kmst_pkg.sv
package kmst_pkg;

  localparam int WEIGHT_W = 16;
  localparam int NODE_W   = 11;
  localparam int COUNT_W  = 12;
  localparam int TOTAL_W  = 32;
  localparam int RANK_W   = 4;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [RANK_W-1:0]   rank_t;

  localparam rank_t  RANK_TOP         = rank_t'(15);
  localparam count_t COUNT_TOP        = count_t'(4095);
  localparam count_t NODE_COUNT_RESET = count_t'(2048);

endpackage

>>> rtl/kmst_if.sv
interface kmst_edge_if import kmst_pkg::*; ();
  logic    valid;
  logic    ready;
  weight_t edge_weight;
  node_t   node_low;
  node_t   node_high;
  logic    final_edge;

  modport source (output valid, output edge_weight, output node_low, output node_high,
                  output final_edge, input ready);
  modport sink (input valid, input edge_weight, input node_low, input node_high,
                input final_edge, output ready);
endinterface

interface kmst_result_if import kmst_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   edge_taken;
  total_t tree_weight;
  logic   tree_done;

  modport source (output valid, output edge_taken, output tree_weight, output tree_done,
                  input ready);
  modport sink (input valid, input edge_taken, input tree_weight, input tree_done,
                output ready);
endinterface

>>> rtl/kmst_ram.sv
module kmst_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kruskal_union_find_mst.sv
// each accepted edge runs two finds, walking the parent links (at most about 11 each) and
// then compressing them, a join and the output state; skipped edges go straight to output
// throughput: one request at a time; in_edge.ready is high only in the idle state
// reset and each node_count write start a clearing pass over all MAX_NODES entries
// of the forest ram; no request is accepted until it ends
module kruskal_union_find_mst import kmst_pkg::*; #(
  parameter int MAX_NODES = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  count_t               cfg_wdata,
  kmst_edge_if.sink            in_edge,
  kmst_result_if.source        out_result
);

  localparam int AW = $clog2(MAX_NODES);

  typedef struct packed {
    rank_t         rank;
    logic [AW-1:0] parent;
  } entry_t;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_COMP  = 3'd3;
  localparam logic [2:0] S_JOIN1 = 3'd4;
  localparam logic [2:0] S_JOIN2 = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  count_t        node_count_r, node_count_nxt;
  total_t        total_r, total_nxt;
  count_t        joined_r, joined_nxt;
  logic          finished_r, finished_nxt;
  weight_t       weight_r, weight_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic          last_r, last_nxt;
  logic          second_r, second_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] v_r, v_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic [AW-1:0] root_a_r, root_a_nxt;
  rank_t         rank_a_r, rank_a_nxt;
  rank_t         rank_b_r, rank_b_nxt;
  logic          taken_r, taken_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_taken_r, out_taken_nxt;
  total_t        out_weight_r, out_weight_nxt;
  logic          out_done_r, out_done_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        rd_q;

  count_t           n_eff;
  logic [TOTAL_W:0] sum;
  logic             skip;
  logic             done_now;

  kmst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_NODES)
  ) u_forest (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_q)
  );

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = count_t'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_eff = count_t'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign sum      = {1'b0, total_r} + (TOTAL_W+1)'(weight_r);
  assign skip     = finished_r || (joined_r >= n_eff) ||
                    (count_t'(in_edge.node_low) >= n_eff) ||
                    (count_t'(in_edge.node_high) >= n_eff);
  assign done_now = finished_r || (joined_r >= n_eff) || last_r;

  assign in_edge.ready         = (state_r == S_IDLE) && !cfg_we;
  assign out_result.valid      = out_valid_r;
  assign out_result.edge_taken = out_taken_r;
  assign out_result.tree_weight = out_weight_r;
  assign out_result.tree_done  = out_done_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    node_count_nxt = node_count_r;
    total_nxt      = total_r;
    joined_nxt     = joined_r;
    finished_nxt   = finished_r;
    weight_nxt     = weight_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    last_nxt       = last_r;
    second_nxt     = second_r;
    cur_nxt        = cur_r;
    v_nxt          = v_r;
    root_nxt       = root_r;
    root_a_nxt     = root_a_r;
    rank_a_nxt     = rank_a_r;
    rank_b_nxt     = rank_b_r;
    taken_nxt      = taken_r;
    out_valid_nxt  = out_valid_r && !out_result.ready;
    out_taken_nxt  = out_taken_r;
    out_weight_nxt = out_weight_r;
    out_done_nxt   = out_done_r;
    ram_we         = 1'b0;
    ram_waddr      = v_r;
    ram_wdata      = '{rank: '0, parent: '0};
    ram_raddr      = cur_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '{rank: '0, parent: clr_idx_r};
        if (32'(clr_idx_r) == MAX_NODES - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        ram_raddr = AW'(in_edge.node_low);
        if (in_edge.valid && in_edge.ready) begin
          weight_nxt = in_edge.edge_weight;
          lo_nxt     = AW'(in_edge.node_low);
          hi_nxt     = AW'(in_edge.node_high);
          last_nxt   = in_edge.final_edge;
          cur_nxt    = AW'(in_edge.node_low);
          second_nxt = 1'b0;
          taken_nxt  = 1'b0;
          state_nxt  = skip ? S_OUT : S_WALK;
        end
      end
      S_WALK: begin
        if (rd_q.parent == cur_r) begin
          root_nxt = cur_r;
          if (second_r) begin
            rank_b_nxt = rd_q.rank;
            v_nxt      = hi_r;
            ram_raddr  = hi_r;
          end else begin
            rank_a_nxt = rd_q.rank;
            v_nxt      = lo_r;
            ram_raddr  = lo_r;
          end
          state_nxt = S_COMP;
        end else begin
          cur_nxt   = rd_q.parent;
          ram_raddr = rd_q.parent;
        end
      end
      S_COMP: begin
        if (v_r == root_r) begin
          if (!second_r) begin
            root_a_nxt = root_r;
            second_nxt = 1'b1;
            cur_nxt    = hi_r;
            ram_raddr  = hi_r;
            state_nxt  = S_WALK;
          end else if (root_a_r == root_r) begin
            state_nxt = S_OUT;
          end else begin
            taken_nxt  = 1'b1;
            total_nxt  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            joined_nxt = (joined_r != COUNT_TOP) ? joined_r + count_t'(1) : joined_r;
            state_nxt  = S_JOIN1;
          end
        end else begin
          // compress: point the visited entry at the root, fetch the next link
          ram_we    = 1'b1;
          ram_waddr = v_r;
          ram_wdata = '{rank: rd_q.rank, parent: root_r};
          v_nxt     = rd_q.parent;
          ram_raddr = rd_q.parent;
        end
      end
      S_JOIN1: begin
        ram_we = 1'b1;
        if (rank_a_r > rank_b_r) begin
          ram_waddr = root_r;
          ram_wdata = '{rank: rank_b_r, parent: root_a_r};
          state_nxt = S_OUT;
        end else begin
          ram_waddr = root_a_r;
          ram_wdata = '{rank: rank_a_r, parent: root_r};
          if (rank_a_r == rank_b_r && rank_b_r != RANK_TOP) begin
            state_nxt = S_JOIN2;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_JOIN2: begin
        ram_we    = 1'b1;
        ram_waddr = root_r;
        ram_wdata = '{rank: rank_b_r + rank_t'(1), parent: root_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_result.ready) begin
          finished_nxt   = done_now;
          out_valid_nxt  = 1'b1;
          out_taken_nxt  = taken_r;
          out_weight_nxt = total_r;
          out_done_nxt   = done_now;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      node_count_nxt = cfg_wdata;
      state_nxt      = S_CLEAR;
      clr_idx_nxt    = '0;
      total_nxt      = '0;
      joined_nxt     = count_t'(1);
      finished_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      node_count_r <= NODE_COUNT_RESET;
      total_r      <= '0;
      joined_r     <= count_t'(1);
      finished_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      node_count_r <= node_count_nxt;
      total_r      <= total_nxt;
      joined_r     <= joined_nxt;
      finished_r   <= finished_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    weight_r     <= weight_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    last_r       <= last_nxt;
    second_r     <= second_nxt;
    cur_r        <= cur_nxt;
    v_r          <= v_nxt;
    root_r       <= root_nxt;
    root_a_r     <= root_a_nxt;
    rank_a_r     <= rank_a_nxt;
    rank_b_r     <= rank_b_nxt;
    taken_r      <= taken_nxt;
    out_taken_r  <= out_taken_nxt;
    out_weight_r <= out_weight_nxt;
    out_done_r   <= out_done_nxt;
  end

`ifndef NO_ASSERTIONS
  // compression write and next link read never hit the same entry
  a_comp_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("compression write collides with read");

  a_joined_bound: assert property (@(posedge clk) disable iff (!rst_n)
    joined_r <= n_eff)
    else $error("joined count exceeds node count");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_we)) |-> (total_r >= $past(total_r)))
    else $error("tree total decreased");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

>>> tb/tb.sv
module tb import kmst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES   = 2048;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LIVE_TARGET = 800;
  localparam int DRAIN_WAIT  = 64;

  typedef struct packed {
    weight_t edge_weight;
    node_t   node_low;
    node_t   node_high;
    logic    final_edge;
  } mst_edge_t;

  typedef struct packed {
    logic   edge_taken;
    total_t tree_weight;
    logic   tree_done;
  } mst_result_t;

  class mst_scoreboard;
    node_t       parent_of [MAX_NODES];
    rank_t       rank_of [MAX_NODES];
    total_t      total;
    count_t      joined;
    bit          finished;
    count_t      node_count;
    mst_result_t pending [$];
    int          errors;
    int          result_index;

    function new();
      node_count = NODE_COUNT_RESET;
      errors = 0;
      result_index = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      for (int i = 0; i < MAX_NODES; i++) begin
        parent_of[i] = node_t'(i);
        rank_of[i] = '0;
      end
      total = '0;
      joined = count_t'(1);
      finished = 1'b0;
    endfunction

    function void set_node_count(count_t value);
      node_count = value;
      clear_forest();
    endfunction

    function int unsigned live_nodes();
      int unsigned n;
      n = node_count;
      if (n == 0) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
    endfunction

    // walk to the root, then point every visited entry straight at it
    function node_t find_root(node_t v);
      node_t r;
      node_t nxt;
      int    steps;
      r = v;
      steps = 0;
      while (parent_of[r] != r && steps < MAX_NODES) begin
        r = parent_of[r];
        steps++;
      end
      steps = 0;
      while (v != r && steps < MAX_NODES) begin
        nxt = parent_of[v];
        parent_of[v] = r;
        v = nxt;
        steps++;
      end
      return r;
    endfunction

    function void merge_roots(node_t a, node_t b);
      if (rank_of[a] > rank_of[b]) begin
        parent_of[b] = a;
      end else begin
        parent_of[a] = b;
        if (rank_of[a] == rank_of[b] && rank_of[b] < RANK_TOP) rank_of[b] = rank_of[b] + 1'b1;
      end
    endfunction

    function void note_request(mst_edge_t e);
      int unsigned      n;
      node_t            a;
      node_t            b;
      logic [TOTAL_W:0] sum;
      mst_result_t      r;
      n = live_nodes();
      r.edge_taken = 1'b0;
      if (joined >= n) finished = 1'b1;
      if (!finished && e.node_low < n && e.node_high < n) begin
        a = find_root(e.node_low);
        b = find_root(e.node_high);
        if (a != b) begin
          sum = {1'b0, total} + e.edge_weight;
          total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          if (joined < COUNT_TOP) joined = joined + 1'b1;
          merge_roots(a, b);
          r.edge_taken = 1'b1;
        end
      end
      if (joined >= n || e.final_edge) finished = 1'b1;
      r.tree_weight = total;
      r.tree_done = finished;
      pending = {pending, r};
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(mst_result_t got);
      mst_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", result_index));
      end else begin
        want = pending.pop_front();
        if (got.edge_taken !== want.edge_taken)
          report($sformatf("result %0d edge_taken %0b, want %0b", result_index,
                           got.edge_taken, want.edge_taken));
        if (got.tree_weight !== want.tree_weight)
          report($sformatf("result %0d tree_weight %0d, want %0d", result_index,
                           got.tree_weight, want.tree_weight));
        if (got.tree_done !== want.tree_done)
          report($sformatf("result %0d tree_done %0b, want %0b", result_index,
                           got.tree_done, want.tree_done));
      end
      result_index++;
    endtask

    task flush();
      if (pending.size() != 0) report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  kmst_edge_if   edge_bus ();
  kmst_result_if result_bus ();

  kruskal_union_find_mst dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_edge   (edge_bus),
    .out_result(result_bus)
  );

  mst_scoreboard sb;
  int            requests_sent = 0;
  int            results_seen = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (edge_bus.valid && edge_bus.ready)
        sb.note_request('{edge_bus.edge_weight, edge_bus.node_low, edge_bus.node_high,
                          edge_bus.final_edge});
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        sb.check_result('{result_bus.edge_taken, result_bus.tree_weight, result_bus.tree_done});
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  function automatic mst_edge_t edge_item(int w, int lo, int hi, bit fin);
    mst_edge_t e;
    e.edge_weight = weight_t'(w);
    e.node_low = node_t'(lo);
    e.node_high = node_t'(hi);
    e.final_edge = fin;
    return e;
  endfunction

  task automatic send_edge(mst_edge_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      edge_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_bus.valid <= 1'b1;
    edge_bus.edge_weight <= e.edge_weight;
    edge_bus.node_low <= e.node_low;
    edge_bus.node_high <= e.node_high;
    edge_bus.final_edge <= e.final_edge;
    do @(posedge clk); while (!edge_bus.ready);
    requests_sent++;
  endtask

  task automatic wait_idle();
    while (results_seen != requests_sent) @(posedge clk);
  endtask

  task automatic write_node_count(count_t value);
    edge_bus.valid <= 1'b0;
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_node_count(value);
  endtask

  // tidy graphs: ascending weights, endpoints in range but for an occasional high one; otherwise broken noise
  task automatic run_graph(count_t nc, int edges, bit tidy);
    int unsigned n;
    int          w;
    int          lo;
    int          hi;
    bit          fin;
    n = (nc == 0) ? 1 : ((nc > MAX_NODES) ? MAX_NODES : nc);
    write_node_count(nc);
    no_idle = ($urandom_range(0, 5) == 0);
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
    for (int i = 0; i < edges; i++) begin
      lo = (tidy || $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, 2047);
      hi = (tidy || $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, 2047);
      if (tidy && $urandom_range(0, 19) == 0) hi = $urandom_range(0, 2047);
      fin = (i == edges - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 59) == 0);
      send_edge(edge_item(w, lo, hi, fin));
      if (tidy) begin
        w = w + $urandom_range(0, 300);
        if (w > 65535) w = 65535;
      end else begin
        w = $urandom_range(0, 65535);
      end
    end
    repeat ($urandom_range(0, 3))
      send_edge(edge_item($urandom_range(0, 65535), $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1), $urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    int n;
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    edge_bus.valid <= 1'b0;
    edge_bus.edge_weight <= '0;
    edge_bus.node_low <= '0;
    edge_bus.node_high <= '0;
    edge_bus.final_edge <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default node count after reset
    send_edge(edge_item(0, 0, 2047, 0));
    send_edge(edge_item(1, 2047, 0, 0));
    send_edge(edge_item(2, 5, 5, 0));
    send_edge(edge_item(65535, 1, 2, 0));
    send_edge(edge_item(65535, 2, 0, 0));
    send_edge(edge_item(7, 1024, 1023, 1));
    send_edge(edge_item(8, 3, 4, 0));
    // zero count acts as a single node
    write_node_count(count_t'(0));
    send_edge(edge_item(3, 0, 0, 0));
    send_edge(edge_item(4, 0, 1, 0));
    write_node_count(count_t'(1));
    send_edge(edge_item(5, 0, 0, 1));
    write_node_count(count_t'(2));
    send_edge(edge_item(1, 1, 0, 0));
    send_edge(edge_item(2, 0, 1, 0));
    // endpoints out of range, same set, final edge
    write_node_count(count_t'(3));
    send_edge(edge_item(0, 0, 3, 0));
    send_edge(edge_item(1, 2047, 1, 0));
    send_edge(edge_item(2, 2, 0, 0));
    send_edge(edge_item(3, 1, 1, 0));
    send_edge(edge_item(4, 1, 2, 1));
    send_edge(edge_item(5, 0, 1, 0));
    // above the maximum acts as the maximum
    write_node_count(count_t'(4095));
    send_edge(edge_item(65535, 2047, 2046, 0));
    send_edge(edge_item(65535, 2046, 1, 0));

    while (requests_sent < LIVE_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        run_graph(count_t'($urandom_range(0, 1)), 3, 1'b1);
      end else if (pick == 1) begin
        n = $urandom_range(0, 2);
        run_graph((n == 0) ? count_t'(2048) : (n == 1) ? count_t'(4095)
                                              : count_t'($urandom_range(0, 4095)), 150, 1'b1);
      end else if (pick == 2) begin
        run_graph(count_t'($urandom_range(2, 60)), $urandom_range(5, 40), 1'b0);
      end else begin
        n = $urandom_range(2, 48);
        run_graph(count_t'(n), $urandom_range(n, 3 * n), 1'b1);
      end
    end

    edge_bus.valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.flush();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
